// ===== design/hbks_pkg.sv =====
// Shared constants, codes and types of the hashed bucket key set.
// Used by the controller, the datapath and the top level.
package hbks_pkg;

    localparam int BUCKETS   = 256;
    localparam int WAYS      = 4;
    localparam int KEY_BYTES = 8;

    localparam int BUCKET_W  = $clog2(BUCKETS);
    localparam int WAY_W     = $clog2(WAYS);
    localparam int KEY_W     = 64;
    localparam int LEN_W     = 4;
    localparam int OP_W      = 2;
    localparam int CNT_W     = 2;

    // Two key bytes go through the hash per cycle.
    localparam int HASH_BYTES_PER_STEP = 2;

    localparam logic [KEY_W-1:0] HASH_SEED  = 64'd5381;
    localparam int               HASH_SHIFT = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_REMOVED   = 3'd5
    } t_status;

    localparam int STATUS_W     = 3;
    localparam int OUT_BUCKET_W = 8;
    localparam int OUT_SLOT_W   = 2;

    localparam int IN_FIELDS_W  = OP_W + KEY_W + LEN_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + KEY_W + OUT_BUCKET_W + OUT_SLOT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [KEY_W-1:0] key;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

    typedef struct packed {
        logic load;
        logic hash_step;
        logic read_en;
        logic update_en;
    } t_dp_cmd;

    typedef struct packed {
        logic hash_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== design/hbks_ctrl.sv =====
// Controller of the hashed bucket key set: sequences hash, row read and update.
// Depends on hbks_pkg for the command and status structs.
module hbks_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hbks_pkg::t_dp_stat i_stat,
    output hbks_pkg::t_dp_cmd  o_cmd
);
    import hbks_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_HASH   = 4'b0010,
        S_READ   = 4'b0100,
        S_UPDATE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_in_ready      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_stat.hash_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read_en = 1'b1;
                n_state       = S_UPDATE;
            end
            S_UPDATE: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.update_en = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/hbks_dp.sv =====
// Datapath of the hashed bucket key set: hash unit, bucket row memory,
// way compare and row update, and the result register. Depends on hbks_pkg.
module hbks_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [hbks_pkg::OP_W-1:0]        i_op,
    input  logic [hbks_pkg::KEY_W-1:0]       i_key,
    input  logic [hbks_pkg::LEN_W-1:0]       i_len,
    input  hbks_pkg::t_dp_cmd                i_cmd,
    output hbks_pkg::t_dp_stat               o_stat,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [hbks_pkg::OUT_DATA_W-1:0]  o_out_data
);
    import hbks_pkg::*;

    // request registers
    logic [OP_W-1:0]  r_op;
    logic [KEY_W-1:0] r_key;
    logic [LEN_W-1:0] r_len;
    logic [KEY_W-1:0] r_hash;
    logic [CNT_W-1:0] r_cnt;

    logic [LEN_W-1:0] len_sat;
    logic [KEY_W-1:0] key_masked;
    logic [KEY_W-1:0] n_hash;
    logic [LEN_W-1:0] next_pos;

    // bucket row memory and row valid bits
    t_row             mem [BUCKETS];
    logic [BUCKETS-1:0] r_row_valid;
    t_row             r_rdata;
    logic             r_rvalid;
    logic [BUCKET_W-1:0] bucket;

    // update logic
    t_row             row_eff;
    t_row             row_new;
    logic [WAYS-1:0]  match;
    logic [WAYS-1:0]  free;
    logic             hit;
    logic             any_free;
    logic [WAY_W-1:0] hit_slot;
    logic [WAY_W-1:0] free_slot;
    logic             shift_done;
    logic             wr_en;
    t_status          status;
    logic [WAY_W-1:0] slot;

    // result register
    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [KEY_W-1:0]        r_out_hash;
    logic [OUT_BUCKET_W-1:0] r_out_bucket;
    logic [OUT_SLOT_W-1:0]   r_out_slot;

    // saturate the length and clear bytes beyond it
    always_comb begin
        len_sat = (i_len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : i_len;
        for (int b = 0; b < KEY_W / 8; b++) begin
            key_masked[b*8 +: 8] = (LEN_W'(b) < len_sat) ? i_key[b*8 +: 8] : 8'd0;
        end
    end

    // hash unit: h = h*33 ^ byte, a pair of bytes per cycle
    always_comb begin
        logic [LEN_W-1:0] pos;
        logic [KEY_W-1:0] h;
        h = r_hash;
        for (int k = 0; k < HASH_BYTES_PER_STEP; k++) begin
            pos = LEN_W'({r_cnt, 1'b0}) + LEN_W'(k);
            if (pos < r_len) begin
                h = ((h << HASH_SHIFT) + h) ^ KEY_W'(r_key[pos[2:0]*8 +: 8]);
            end
        end
        n_hash   = h;
        next_pos = LEN_W'({r_cnt, 1'b0}) + LEN_W'(HASH_BYTES_PER_STEP);
    end

    assign bucket = r_hash[BUCKET_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_key  <= key_masked;
            r_len  <= len_sat;
            r_hash <= HASH_SEED;
            r_cnt  <= '0;
        end else if (i_cmd.hash_step) begin
            r_hash <= n_hash;
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    // row memory: registered read, whole-row write
    always_ff @(posedge i_clk) begin
        if (i_cmd.read_en) begin
            r_rdata <= mem[bucket];
        end
        if (wr_en) begin
            mem[bucket] <= row_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rvalid    <= 1'b0;
        end else begin
            if (i_cmd.read_en) begin
                r_rvalid <= r_row_valid[bucket];
            end
            if (wr_en) begin
                r_row_valid[bucket] <= 1'b1;
            end
        end
    end

    // compare the ways; a row never written reads as all empty
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            row_eff[w].key = r_rdata[w].key;
            row_eff[w].len = r_rvalid ? r_rdata[w].len : '0;
            match[w] = (row_eff[w].len != '0) && (row_eff[w].len == r_len)
                       && (row_eff[w].key == r_key);
            free[w]  = (row_eff[w].len == '0);
        end
        hit       = |match;
        any_free  = |free;
        hit_slot  = '0;
        free_slot = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) hit_slot = WAY_W'(w);
            if (free[w])  free_slot = WAY_W'(w);
        end
    end

    // decide the result and the new row
    always_comb begin
        status     = ST_NOT_FOUND;
        slot       = '0;
        wr_en      = 1'b0;
        row_new    = row_eff;
        shift_done = 1'b0;
        if (r_len != '0) begin
            case (r_op)
                OP_INSERT: begin
                    if (hit) begin
                        status = ST_PRESENT;
                        slot   = hit_slot;
                    end else if (any_free) begin
                        status                 = ST_INSERTED;
                        slot                   = free_slot;
                        row_new[free_slot].key = r_key;
                        row_new[free_slot].len = r_len;
                        wr_en                  = i_cmd.update_en;
                    end else begin
                        status = ST_FULL;
                    end
                end
                OP_FIND: begin
                    if (hit) begin
                        status = ST_FOUND;
                        slot   = hit_slot;
                    end
                end
                OP_REMOVE: begin
                    if (hit) begin
                        status = ST_REMOVED;
                        slot   = hit_slot;
                        wr_en  = i_cmd.update_en;
                        // shift later slots down until the first empty one
                        for (int j = 0; j < WAYS - 1; j++) begin
                            if (!shift_done && (WAY_W'(j) >= hit_slot)) begin
                                if (row_eff[j+1].len == '0) begin
                                    row_new[j] = '0;
                                    shift_done = 1'b1;
                                end else begin
                                    row_new[j] = row_eff[j+1];
                                end
                            end
                        end
                        if (!shift_done) begin
                            row_new[WAYS-1] = '0;
                        end
                    end
                end
                default: begin
                    status = ST_NOT_FOUND;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.update_en) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update_en) begin
            r_out_status <= status;
            r_out_hash   <= r_hash;
            r_out_bucket <= OUT_BUCKET_W'(bucket);
            r_out_slot   <= OUT_SLOT_W'(slot);
        end
    end

    assign o_stat.hash_last = (next_pos >= r_len);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{OUT_PAD_W{1'b0}}, r_out_slot, r_out_bucket, r_out_hash,
                          r_out_status};

endmodule

// ===== design/hashed_bucket_key_set_core.sv =====
// Hashed bucket key set: a set of keys of up to 8 bytes in a 256 x 4 bucket table.
// Instantiates hbks_ctrl and hbks_dp; depends on hbks_pkg.
//
// Usage:
//   Slave channel (i_s_*) takes one request per transfer: operation, key bytes
//   and key length. Master channel (o_m_*) returns one result per request:
//   status, DJB33X hash, bucket and slot, in request order.
//   One request is worked on at a time. After the transfer, the hash unit folds
//   two key bytes per cycle, then the bucket row memory is read (registered
//   read port), and the row is compared and written back in the update step,
//   which also loads the result register. The next request is taken in the
//   idle state after that update; the result shows on o_m_* the cycle after it.
//   The result register frees the slave side: the next request is taken and
//   hashed while a result waits. If the receiver stalls, the following
//   request holds in its update step until the result register drains.
//   Reset clears the row valid bits of all 256 buckets at once, so the table
//   starts empty with no clearing pass; the slave side is ready right after.
module hashed_bucket_key_set_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // operation[1:0], key_bytes[65:2], key_length[69:66], zero pad[71:70]
    input  logic [hbks_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // status[2:0], hash_value[66:3], bucket_index[74:67], slot_index[76:75],
    // zero pad[79:77]
    output logic [hbks_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import hbks_pkg::*;

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [OP_W-1:0]  in_op;
    logic [KEY_W-1:0] in_key;
    logic [LEN_W-1:0] in_len;

    assign in_op  = i_s_tdata[OP_W-1:0];
    assign in_key = i_s_tdata[OP_W +: KEY_W];
    assign in_len = i_s_tdata[OP_W + KEY_W +: LEN_W];

    hbks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hbks_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (in_op),
        .i_key       (in_key),
        .i_len       (in_len),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_data  (o_m_tdata)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for hashed_bucket_key_set_core: streams insert, find and
// remove requests, predicts each result and compares the result stream.
// Depends on hbks_pkg and the core.
module tb;
    import hbks_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 1000;
    localparam int PRINT_LIMIT = 40;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
    } t_request;

    typedef struct {
        t_status                 status;
        logic [KEY_W-1:0]        hash;
        logic [OUT_BUCKET_W-1:0] bucket;
        logic [OUT_SLOT_W-1:0]   slot;
    } t_set_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;

    hashed_bucket_key_set_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the bucket table.
    logic [KEY_W-1:0] stored_key [BUCKETS*WAYS];
    logic [LEN_W-1:0] stored_len [BUCKETS*WAYS] = '{default: '0};

    t_request    pending_req [$];
    t_set_result expected_results [$];
    t_request    driven_req;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_cnt = 0;
    int reqs_accepted = 0;
    int results_checked = 0;
    int idle_cycles = 0;
    int status_seen [6] = '{default: 0};

    function automatic logic [KEY_W-1:0] key_mask(logic [KEY_W-1:0] k, int unsigned n);
        if (n >= KEY_BYTES)
            return k;
        return k & ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function automatic logic [KEY_W-1:0] calc_key_hash(logic [KEY_W-1:0] k, int unsigned n);
        logic [KEY_W-1:0] h;
        h = HASH_SEED;
        for (int i = 0; i < n; i++)
            h = ((h << HASH_SHIFT) + h) ^ {56'd0, k[8*i +: 8]};
        return h;
    endfunction

    // Apply one request to the shadow table and return its result.
    function automatic t_set_result apply_request(t_request r);
        t_set_result res;
        int unsigned n;
        logic [KEY_W-1:0] k;
        int bkt, base, hit, a;
        logic done;
        n = (r.len > KEY_BYTES) ? KEY_BYTES : r.len;
        k = key_mask(r.key, n);
        res.hash = calc_key_hash(k, n);
        bkt = int'(res.hash % BUCKETS);
        base = bkt * WAYS;
        res.bucket = bkt[OUT_BUCKET_W-1:0];
        res.status = ST_NOT_FOUND;
        res.slot = '0;
        if (n != 0) begin
            hit = -1;
            for (int s = 0; s < WAYS; s++)
                if (hit < 0 && stored_len[base+s] != 0 && stored_len[base+s] == n
                    && stored_key[base+s] == k)
                    hit = s;
            case (r.op)
                OP_INSERT: begin
                    if (hit >= 0) begin
                        res.status = ST_PRESENT;
                        res.slot = hit[OUT_SLOT_W-1:0];
                    end else begin
                        res.status = ST_FULL;
                        for (int s = 0; s < WAYS; s++)
                            if (res.status == ST_FULL && stored_len[base+s] == 0) begin
                                stored_key[base+s] = k;
                                stored_len[base+s] = n[LEN_W-1:0];
                                res.status = ST_INSERTED;
                                res.slot = s[OUT_SLOT_W-1:0];
                            end
                    end
                end
                OP_FIND: begin
                    if (hit >= 0) begin
                        res.status = ST_FOUND;
                        res.slot = hit[OUT_SLOT_W-1:0];
                    end
                end
                OP_REMOVE: begin
                    if (hit >= 0) begin
                        res.status = ST_REMOVED;
                        res.slot = hit[OUT_SLOT_W-1:0];
                        done = 1'b0;
                        // shift later slots down; the last slot is just emptied
                        for (int j = hit; j < WAYS; j++) begin
                            a = base + j;
                            if (!done) begin
                                if (j == WAYS - 1) begin
                                    stored_len[a] = '0;
                                    done = 1'b1;
                                end else if (stored_len[a+1] == 0) begin
                                    stored_len[a] = '0;
                                    done = 1'b1;
                                end else begin
                                    stored_key[a] = stored_key[a+1];
                                    stored_len[a] = stored_len[a+1];
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        return res;
    endfunction

    // Random key of n bytes that lands in the given bucket; bytes above n are noise.
    function automatic logic [KEY_W-1:0] key_for_bucket(int bkt, int unsigned n);
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        while (int'(calc_key_hash(key_mask(k, n), n) % BUCKETS) != bkt)
            k = {$urandom, $urandom};
        return k;
    endfunction

    task automatic push_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, logic [LEN_W-1:0] len);
        t_request r;
        r.op = op;
        r.key = key;
        r.len = len;
        pending_req.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
        if (mismatch_cnt < PRINT_LIMIT)
            $display("%0t: %s mismatch at result %0d: got %h, want %h",
                     $time, what, results_checked, got, want);
        mismatch_cnt++;
    endtask

    // Most traffic hits a few hot buckets so they fill, overflow and shift.
    task automatic queue_random_phase(int count);
        int hot [3];
        logic [KEY_W-1:0] pool_key [$];
        logic [LEN_W-1:0] pool_len [$];
        int sel, roll, pick;
        logic [LEN_W-1:0] n;
        logic [KEY_W-1:0] k, noise;
        logic [OP_W-1:0] op;
        for (int b = 0; b < 3; b++) begin
            hot[b] = $urandom_range(BUCKETS - 1);
            for (int j = 0; j < 6; j++) begin
                n = LEN_W'($urandom_range(1, KEY_BYTES));
                pool_key.push_back(key_for_bucket(hot[b], n));
                pool_len.push_back(n);
            end
        end
        repeat (count) begin
            roll = $urandom_range(99);
            noise = {$urandom, $urandom};
            if (roll < 78) begin
                sel = $urandom_range(pool_key.size() - 1);
                n = pool_len[sel];
                if (n == KEY_BYTES && $urandom_range(3) == 0)
                    n = LEN_W'($urandom_range(KEY_BYTES + 1, 15));
                k = key_mask(pool_key[sel], n) | (noise & ~key_mask('1, n));
                pick = $urandom_range(99);
                op = (pick < 45) ? OP_INSERT : (pick < 70) ? OP_FIND : OP_REMOVE;
                push_req(op, k, n);
            end else if (roll < 88) begin
                push_req(OP_W'($urandom_range(2)), noise, LEN_W'($urandom_range(15)));
            end else if (roll < 94) begin
                push_req(OP_UNUSED, noise, LEN_W'($urandom_range(15)));
            end else begin
                push_req(OP_W'($urandom_range(3)), noise, '0);
            end
        end
    endtask

    // Driver: present the next request once the current one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(apply_request(driven_req));
                reqs_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    driven_req <= pending_req[0];
                    s_data <= {{(IN_DATA_W-IN_FIELDS_W){1'b0}}, pending_req[0].len,
                               pending_req[0].key, pending_req[0].op};
                    void'(pending_req.pop_front());
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_set_result want;
        logic [STATUS_W-1:0]     got_status;
        logic [KEY_W-1:0]        got_hash;
        logic [OUT_BUCKET_W-1:0] got_bucket;
        logic [OUT_SLOT_W-1:0]   got_slot;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got_status = m_data[STATUS_W-1:0];
                got_hash   = m_data[STATUS_W +: KEY_W];
                got_bucket = m_data[STATUS_W+KEY_W +: OUT_BUCKET_W];
                got_slot   = m_data[STATUS_W+KEY_W+OUT_BUCKET_W +: OUT_SLOT_W];
                if (got_status <= ST_REMOVED)
                    status_seen[got_status]++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unrequested result", m_data[KEY_W-1:0], '0);
                end else begin
                    want = expected_results.pop_front();
                    if (got_status != want.status)
                        report_mismatch("status", KEY_W'(got_status), KEY_W'(want.status));
                    if (got_hash != want.hash)
                        report_mismatch("hash", got_hash, want.hash);
                    if (got_bucket != want.bucket)
                        report_mismatch("bucket", KEY_W'(got_bucket), KEY_W'(want.bucket));
                    if (got_slot != want.slot)
                        report_mismatch("slot", KEY_W'(got_slot), KEY_W'(want.slot));
                end
                results_checked++;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: count cycles with work outstanding but no transfer on either side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)
                || (!s_valid && pending_req.size() == 0 && expected_results.size() == 0)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, expected_results.size());
                $display("tb NOT OK");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        logic [KEY_W-1:0] b0 [5];
        logic [LEN_W-1:0] b0_len [5];
        logic [KEY_W-1:0] top_key;
        int directed_cnt;

        // Empty keys never hit, whatever the operation.
        push_req(OP_INSERT, {$urandom, $urandom}, '0);
        push_req(OP_FIND, {$urandom, $urandom}, '0);
        push_req(OP_REMOVE, {$urandom, $urandom}, '0);
        // Full-width keys; an overlong length saturates to eight bytes.
        push_req(OP_INSERT, '1, 4'd8);
        push_req(OP_FIND, '1, 4'd15);
        push_req(OP_INSERT, '0, 4'd8);
        // Bytes above the length are ignored for hash, compare and storage.
        push_req(OP_INSERT, 64'h1234_5678_9A63_6261, 4'd3);
        push_req(OP_FIND, 64'hFFFF_FFFF_FF63_6261, 4'd3);
        // Fill bucket 0, overflow it, then remove from the last and a middle slot.
        for (int i = 0; i < 5; i++) begin
            b0_len[i] = LEN_W'(2 + i);
            b0[i] = key_for_bucket(0, b0_len[i]);
        end
        for (int i = 0; i < 5; i++)
            push_req(OP_INSERT, b0[i], b0_len[i]);
        push_req(OP_INSERT, b0[2], b0_len[2]);
        push_req(OP_FIND, b0[3], b0_len[3]);
        push_req(OP_REMOVE, b0[3], b0_len[3]);
        push_req(OP_INSERT, b0[4], b0_len[4]);
        push_req(OP_REMOVE, b0[1], b0_len[1]);
        push_req(OP_FIND, b0[4], b0_len[4]);
        push_req(OP_REMOVE, b0[1], b0_len[1]);
        push_req(OP_UNUSED, b0[0], b0_len[0]);
        // Top bucket with a one-byte key.
        top_key = key_for_bucket(BUCKETS - 1, 1);
        push_req(OP_INSERT, top_key, 4'd1);
        push_req(OP_REMOVE, top_key, 4'd1);
        push_req(OP_FIND, top_key, 4'd1);
        directed_cnt = pending_req.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 74;
        queue_random_phase(125);
        while (pending_req.size() != 0)
            @(posedge i_clk);
        send_idle_pct = 74;
        recv_idle_pct = 21;
        queue_random_phase(125);
        while (pending_req.size() != 0)
            @(posedge i_clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_phase(125);

        while (pending_req.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("%0d requests (%0d directed), %0d results checked, %0d mismatches",
                 reqs_accepted, directed_cnt, results_checked, mismatch_cnt);
        $display("inserted %0d, present %0d, full %0d, found %0d, not found %0d, removed %0d",
                 status_seen[ST_INSERTED], status_seen[ST_PRESENT], status_seen[ST_FULL],
                 status_seen[ST_FOUND], status_seen[ST_NOT_FOUND], status_seen[ST_REMOVED]);
        if (mismatch_cnt == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
